[rtl/core/mpmp_pkg.sv]
package mpmp_pkg;

	localparam int NODE_COUNT_DEF  = 16;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int INDEX_BITS = 4;
	localparam int FIELD_BITS = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

endpackage

[rtl/core/min_plus_matrix_product.sv]
// Channel | Signals                                  | Carries
// --------+------------------------------------------+--------------------------------
// in      | in_valid, in_ready, operation, row, col, | one write item or one query item
//         | weight                                   |
// out     | out_valid, out_ready, distance           | one product entry per query
//
// A write item is stored as it is accepted. A query walks NODE_COUNT weight pairs,
// one pair a cycle from the two read ports of the weight store, in ISSUE, then DRAIN
// and FINISH; its result shows once the output register is free, and the next item
// is taken from that cycle on. An out-of-range query goes straight to FINISH.
// After reset the store is swept to no-edge, one entry a cycle, over all
// NODE_COUNT * NODE_COUNT entries, with in_ready low.
// A result waiting on out_ready lets write items in; a finished query holds until
// the output register is free.
module min_plus_matrix_product
	import mpmp_pkg::*;
#(
	parameter int NODE_COUNT  = NODE_COUNT_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [INDEX_BITS-1:0] row,
	input  logic [INDEX_BITS-1:0] col,
	input  logic [FIELD_BITS-1:0] weight,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [FIELD_BITS-1:0] distance
);

	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int DEPTH  = NODE_COUNT * NODE_COUNT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [WEIGHT_BITS-1:0] INF = {WEIGHT_BITS{1'b1}};

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_ISSUE  = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [WEIGHT_BITS-1:0] mem [DEPTH];

	logic [2:0]             state_q;
	logic [ADDR_W-1:0]      clr_addr_q;
	logic [IDX_W-1:0]       k_q;
	logic [IDX_W-1:0]       row_q;
	logic [IDX_W-1:0]       col_q;
	logic [WEIGHT_BITS-1:0] best_q;
	logic [FIELD_BITS-1:0]  distance_q;
	logic                   out_valid_q;

	logic [WEIGHT_BITS-1:0] rd_a_s1;
	logic [WEIGHT_BITS-1:0] rd_b_s1;
	logic                   diag_a_s1;
	logic                   diag_b_s1;
	logic                   valid_s1;

	logic                   in_fire;
	logic                   in_range;
	logic                   we;
	logic [ADDR_W-1:0]      waddr;
	logic [WEIGHT_BITS-1:0] wdata;
	logic [ADDR_W-1:0]      addr_a;
	logic [ADDR_W-1:0]      addr_b;
	logic [WEIGHT_BITS-1:0] term_a;
	logic [WEIGHT_BITS-1:0] term_b;
	logic [WEIGHT_BITS:0]   sum_w;
	logic [WEIGHT_BITS-1:0] sum_sat;
	logic                   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign in_range  = (int'(row) < NODE_COUNT) && (int'(col) < NODE_COUNT);
	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = INF;
		end else begin
			we    = in_fire && (operation == OP_WRITE) && in_range;
			waddr = ADDR_W'(row) * ADDR_W'(NODE_COUNT) + ADDR_W'(col);
			wdata = WEIGHT_BITS'(weight);
		end
	end

	assign addr_a = ADDR_W'(row_q) * ADDR_W'(NODE_COUNT) + ADDR_W'(k_q);
	assign addr_b = ADDR_W'(k_q) * ADDR_W'(NODE_COUNT) + ADDR_W'(col_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_s1 <= mem[addr_a];
		rd_b_s1 <= mem[addr_b];
	end

	always_ff @(posedge clk) begin
		diag_a_s1 <= (row_q == k_q);
		diag_b_s1 <= (k_q == col_q);
	end

	assign term_a  = diag_a_s1 ? '0 : rd_a_s1;
	assign term_b  = diag_b_s1 ? '0 : rd_b_s1;
	assign sum_w   = {1'b0, term_a} + {1'b0, term_b};
	assign sum_sat = (sum_w >= {1'b0, INF}) ? INF : sum_w[WEIGHT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_ISSUE);
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire && (operation == OP_QUERY)) begin
						k_q     <= '0;
						state_q <= in_range ? ST_ISSUE : ST_FINISH;
					end
				end
				ST_ISSUE: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == IDX_W'(NODE_COUNT - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (operation == OP_QUERY)) begin
			row_q  <= IDX_W'(row);
			col_q  <= IDX_W'(col);
			best_q <= INF;
		end else if (valid_s1 && (sum_sat < best_q)) begin
			best_q <= sum_sat;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			distance_q <= FIELD_BITS'(best_q);
		end
	end

endmodule
